### rtl/weekly_schedule_thermostat_macros.svh
// Assertion macros shared by the thermostat RTL
`ifndef WEEKLY_SCHEDULE_THERMOSTAT_MACROS_SVH
`define WEEKLY_SCHEDULE_THERMOSTAT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define WST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define WST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wst_pkg.sv
// Types and constants of the weekly schedule thermostat
package wst_pkg;

    typedef struct packed {
        logic               action;
        logic [31:0]        unix_time;
        logic [2:0]         weekday;
        logic signed [15:0] current_temp;
        logic [4:0]         entry_index;
        logic [13:0]        entry_minute;
        logic signed [15:0] entry_temp;
    } cmd_t;

    typedef struct packed {
        logic               heater_on;
        logic signed [15:0] target_temp;
        logic [4:0]         active_entry;
        logic               schedule_used;
        logic               fell_back;
    } result_t;

    typedef struct packed {
        logic               valid;
        logic [13:0]        now;
        logic [5:0]         len;
        logic               found;
        logic               wrap;
        logic [4:0]         sel;
        logic signed [15:0] sel_target;
        logic signed [15:0] prev_target;
        logic signed [15:0] last_target;
    } probe_t;

    typedef struct packed {
        logic               en;
        logic [4:0]         index;
        logic [13:0]        minute;
        logic signed [15:0] temp;
    } wr_t;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_MANUAL = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    localparam logic signed [15:0] MANUAL_RESET = 16'sd1800;

    localparam int LEN_W = 6;

    // floor(x/15) for x below 2**30: (x * RECIP_15) >> 34
    localparam logic [30:0] RECIP_15 = 31'd1145324613;
    localparam int          SHIFT_15 = 34;
    // floor(x/45) for x below 2**22: (x * RECIP_45) >> 28
    localparam logic [22:0] RECIP_45 = 23'd5965233;
    localparam int          SHIFT_45 = 28;

    localparam logic [10:0] MIN_PER_DAY = 11'd1440;

endpackage

### rtl/wst_time.sv
// Unix time and weekday to minute of the week, three registered stages
module wst_time
    import wst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] unix_time,
    input  logic [2:0]  weekday,
    output logic        now_valid,
    output logic [13:0] now
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [26:0] q1_reg, q1b_reg;
    logic [15:0] qq_reg;
    logic [2:0]  wd1_reg, wd2_reg;
    logic [13:0] now_reg;

    logic [60:0] prod1;
    logic [44:0] prod2;
    logic [26:0] q1_next;
    logic [15:0] qq_next;
    logic [26:0] day_base;
    logic [10:0] min_of_day;
    logic [13:0] now_next;

    // minutes since epoch: (t >> 2) / 15
    assign prod1   = 61'(unix_time[31:2]) * 61'(RECIP_15);
    assign q1_next = 27'(prod1 >> SHIFT_15);

    // days since epoch: (q1 >> 5) / 45
    assign prod2   = 45'(q1_reg[26:5]) * 45'(RECIP_45);
    assign qq_next = 16'(prod2 >> SHIFT_45);

    assign day_base   = 27'(qq_reg) * 27'(MIN_PER_DAY);
    assign min_of_day = 11'(q1b_reg - day_base);
    assign now_next   = 14'(14'(wd2_reg) * 14'(MIN_PER_DAY)) + 14'(min_of_day);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q1_reg  <= q1_next;
        wd1_reg <= weekday;
        q1b_reg <= q1_reg;
        qq_reg  <= qq_next;
        wd2_reg <= wd1_reg;
        now_reg <= now_next;
    end

    assign now_valid = v3_reg;
    assign now       = now_reg;

endmodule

### rtl/wst_cell.sv
// One schedule cell: holds an entry and passes the search probe on
module wst_cell
    import wst_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  wr_t    wr,
    input  probe_t probe_in,
    output probe_t probe_out
);

    logic [13:0]        minute_reg;
    logic signed [15:0] target_reg;
    probe_t             probe_reg;
    probe_t             probe_next;
    logic               in_range;
    logic               is_last;

    assign in_range = 32'(probe_in.len) > INDEX;
    assign is_last  = 32'(probe_in.len) == INDEX + 1;

    always_comb
    begin
        probe_next = probe_in;
        if (probe_in.valid && in_range)
        begin
            if (!probe_in.found && (minute_reg > probe_in.now))
            begin
                probe_next.found = 1'b1;
                if (INDEX == 0)
                begin
                    probe_next.wrap = 1'b1;
                end
                else
                begin
                    probe_next.sel        = 5'(INDEX - 1);
                    probe_next.sel_target = probe_in.prev_target;
                end
            end
            if (is_last)
            begin
                probe_next.last_target = target_reg;
            end
            probe_next.prev_target = target_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (32'(wr.index) == INDEX))
        begin
            minute_reg <= wr.minute;
            target_reg <= wr.temp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

### rtl/weekly_schedule_thermostat.sv
// Weekly schedule thermostat top level: control, registers and cell chain
//
//  channel   handshake                  word
//  command   start in, busy out         cmd   (cmd_t)
//  result    done out, one cycle        result (result_t)
//  config    APB psel/penable/pwrite    pwdata, prdata at paddr 0, 4, 8
//
// A scheduled tick passes three stages of time conversion, then the registered
// probe of each cell of the search chain. Writes, manual and fallback ticks go
// from acceptance straight to finish. busy is high from acceptance until the
// cycle that shows done. Reset clears mode, length, heater and fallback latch and
// sets manual to MANUAL_RESET; schedule entries are not cleared. The receiver
// cannot stall: done is high for one cycle; result holds until the next finish.
module weekly_schedule_thermostat
    import wst_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "weekly_schedule_thermostat_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [1:0] K_WRITE  = 2'd0;
    localparam logic [1:0] K_MANUAL = 2'd1;
    localparam logic [1:0] K_FALL   = 2'd2;
    localparam logic [1:0] K_SCHED  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [1:0]         kind_reg, kind_next;
    logic               mode_reg;
    logic signed [15:0] manual_reg;
    logic [LEN_W-1:0]   length_reg;
    logic               heater_reg, heater_next;
    logic               fall_reg, fall_next;
    logic               done_reg;
    result_t            result_reg, result_next;
    logic signed [15:0] temp_reg;
    logic signed [15:0] sched_target_reg;
    logic [4:0]         sched_sel_reg;

    logic               accept;
    logic               cfg_we;
    logic [LEN_W-1:0]   len_sat;
    logic               now_valid;
    logic [13:0]        now;
    wr_t                wr;
    probe_t             chain [0:MAX_ENTRIES];
    probe_t             tail;
    logic               tail_wrap;
    logic signed [15:0] target;

    assign busy   = state_reg != S_IDLE;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    assign len_sat = (32'(length_reg) > MAX_ENTRIES) ? LEN_W'(MAX_ENTRIES) : length_reg;

    always_comb
    begin
        if (cmd.action == ACT_WRITE)
        begin
            kind_next = K_WRITE;
        end
        else if (mode_reg && !fall_reg)
        begin
            kind_next = (len_sat == '0) ? K_FALL : K_SCHED;
        end
        else
        begin
            kind_next = K_MANUAL;
        end
    end

    assign wr.en     = accept && (cmd.action == ACT_WRITE);
    assign wr.index  = cmd.entry_index;
    assign wr.minute = cmd.entry_minute;
    assign wr.temp   = cmd.entry_temp;

    wst_time u_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (accept && (kind_next == K_SCHED)),
        .unix_time (cmd.unix_time),
        .weekday   (cmd.weekday),
        .now_valid (now_valid),
        .now       (now)
    );

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = now_valid;
        chain[0].now   = now;
        chain[0].len   = len_sat;
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        wst_cell #(
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr        (wr),
            .probe_in  (chain[i]),
            .probe_out (chain[i+1])
        );
    end

    assign tail      = chain[MAX_ENTRIES];
    assign tail_wrap = !tail.found || tail.wrap;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (kind_next == K_SCHED) ? S_WALK : S_FIN;
                end
            end
            S_WALK:
            begin
                if (tail.valid)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign target = (kind_reg == K_SCHED) ? sched_target_reg : manual_reg;

    always_comb
    begin
        result_next = '0;
        heater_next = heater_reg;
        fall_next   = fall_reg;
        case (kind_reg)
            K_WRITE:
            begin
            end
            K_FALL:
            begin
                fall_next                 = 1'b1;
                result_next.fell_back     = 1'b1;
                result_next.target_temp   = manual_reg;
            end
            K_MANUAL, K_SCHED:
            begin
                result_next.target_temp = target;
                if (kind_reg == K_SCHED)
                begin
                    result_next.active_entry  = sched_sel_reg;
                    result_next.schedule_used = 1'b1;
                end
                if ($signed(temp_reg) < $signed(target))
                begin
                    heater_next = 1'b1;
                end
                else if ($signed(temp_reg) > $signed(target))
                begin
                    heater_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        result_next.heater_on = heater_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= K_WRITE;
            mode_reg   <= 1'b0;
            manual_reg <= MANUAL_RESET;
            length_reg <= '0;
            heater_reg <= 1'b0;
            fall_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == S_FIN;
            if (accept)
            begin
                kind_reg <= kind_next;
            end
            if (state_reg == S_FIN)
            begin
                heater_reg <= heater_next;
                fall_reg   <= fall_next;
            end
            if (cfg_we)
            begin
                case (paddr[3:2])
                    REG_MODE:
                    begin
                        mode_reg <= pwdata[0];
                        fall_reg <= 1'b0;
                    end
                    REG_MANUAL:
                    begin
                        manual_reg <= pwdata[15:0];
                    end
                    REG_LENGTH:
                    begin
                        length_reg <= pwdata[LEN_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_reg <= cmd.current_temp;
        end
        if ((state_reg == S_WALK) && tail.valid)
        begin
            sched_target_reg <= tail_wrap ? tail.last_target : tail.sel_target;
            sched_sel_reg    <= tail_wrap ? 5'(tail.len - 6'd1) : tail.sel;
        end
        if (state_reg == S_FIN)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:   prdata = {31'd0, mode_reg};
            REG_MANUAL: prdata = {{16{manual_reg[15]}}, manual_reg};
            REG_LENGTH: prdata = {{(32 - LEN_W){1'b0}}, length_reg};
            default:    prdata = '0;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    `WST_ASSERT_IMP(a_done_idle, done_reg, !busy, "done shown while busy")
    `WST_ASSERT_NEXT(a_fin_done, state_reg == S_FIN, done_reg, "finish without done")
    `WST_ASSERT_IMP(a_tail_walk, tail.valid, state_reg == S_WALK, "probe left chain outside walk")
    `WST_ASSERT_IMP(a_fell_latch, done_reg && result_reg.fell_back, fall_reg && !result_reg.schedule_used, "fallback not latched")

endmodule
